/* design/t2fb_pkg.sv */
// Shared constants for the text-to-page-buffer renderer.
package t2fb_pkg;

  localparam int GLYPH_W = 8;
  localparam int GLYPH_H = 8;

  localparam int KIND_W   = 2;
  localparam int CODE_W   = 8;
  localparam int GLYPH_BITS_W = GLYPH_W * GLYPH_H;
  localparam int RADDR_W  = 13;
  localparam int BYTE_W   = 8;
  localparam int COL_W    = 9;
  localparam int ROW_W    = 7;
  localparam int GAP_W    = 4;

  // Stream word widths, padded to whole bytes.
  localparam int S_TDATA_W = 88;
  localparam int M_TDATA_W = 32;

  localparam logic [KIND_W-1:0] KIND_CHAR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

  localparam logic [CODE_W-1:0] CODE_NEWLINE   = 8'h0A;
  localparam logic [CODE_W-1:0] FIRST_DRAWABLE = 8'h21;
  localparam logic [CODE_W-1:0] DRAWABLE_COUNT = 8'd224;

  localparam logic [BYTE_W-1:0] BYTE_WHITE = 8'hFF;

endpackage

/* design/t2fb_page_ram.sv */
// Page buffer memory: one write port and one registered read port.
module t2fb_page_ram #(
  parameter int DEPTH = 4736,
  parameter int AW    = 13
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [AW-1:0]                 waddr,
  input  logic [t2fb_pkg::BYTE_W-1:0]   wdata,
  input  logic [AW-1:0]                 raddr,
  output logic [t2fb_pkg::BYTE_W-1:0]   rdata
);
  import t2fb_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* design/t2fb_mask_unit.sv */
// Shared pixel mask unit: places one glyph column over a buffer byte and clears its pixels.
module t2fb_mask_unit (
  input  logic [t2fb_pkg::GLYPH_W-1:0] line,
  input  logic [2:0]                   shift,
  input  logic                         upper,
  input  logic [t2fb_pkg::BYTE_W-1:0]  rd_byte,
  output logic [t2fb_pkg::BYTE_W-1:0]  wr_byte
);
  import t2fb_pkg::*;

  logic [GLYPH_W-1:0]   rev;
  logic [2*BYTE_W-1:0]  span;
  logic [BYTE_W-1:0]    mask;

  // Pixel i of the column lands at bit (7 - shift + i) of the byte pair.
  always_comb begin
    for (int i = 0; i < GLYPH_W; i++) begin
      rev[i] = line[GLYPH_W-1-i];
    end
    span = {{BYTE_W{1'b0}}, rev} << (3'd7 - shift);
    mask = upper ? span[2*BYTE_W-1:BYTE_W] : span[BYTE_W-1:0];
  end

  assign wr_byte = rd_byte & ~mask;

endmodule

/* design/text_to_framebuffer_renderer_core.sv */
// Top level of the text renderer: cursor, sequencer and stream ports.
//
// Input words arrive on s_tvalid/s_tready. s_tuser carries the kind: a
// character, a clear of the page buffer with cursor home, or a read of one
// buffer byte. Each input word yields exactly one output word on
// m_tvalid/m_tready carrying the read byte, the cursor after the step and a
// flag that tells whether a glyph was drawn. line_gap is written through
// cfg_wen/cfg_wdata; the user must write it only while the block is idle, which
// the block itself does not enforce. A drawable character touches up to two
// buffer bytes in each of its eight columns, and every byte is a read then a
// write through the single memory port pair. Newlines, non-drawable codes and
// unused kinds go straight to the finishing state; a byte read passes through
// the read data state first. A clear sweeps the whole buffer one byte a cycle,
// PANEL_LONG * PANEL_SHORT / 8 bytes (4736 by default), then answers.
// After reset the same sweep runs with s_tready low and no output word.
// One item is in work at a time; s_tready is high only when the sequencer is
// idle. A finished result waits in the output register while the receiver
// stalls, and the next input word may be accepted meanwhile; its result is
// held back until the register is free.
module text_to_framebuffer_renderer_core #(
  parameter int PANEL_LONG  = 296,
  parameter int PANEL_SHORT = 128
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // char_code [7:0], glyph_bits [71:8], read_address [84:72], zero above.
  input  logic [t2fb_pkg::S_TDATA_W-1:0]   s_tdata,
  // kind [1:0].
  input  logic [t2fb_pkg::KIND_W-1:0]      s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // read_data [7:0], cursor_col [16:8], cursor_row [23:17], drawn [24], zero above.
  output logic [t2fb_pkg::M_TDATA_W-1:0]   m_tdata,
  input  logic                             cfg_wen,
  input  logic [t2fb_pkg::GAP_W-1:0]       cfg_wdata
);
  import t2fb_pkg::*;

  localparam int ROW_BYTES  = PANEL_SHORT / 8;
  localparam int PAGE_BYTES = ROW_BYTES * PANEL_LONG;
  localparam int AW = $clog2(PAGE_BYTES);
  localparam int LW = $clog2(PANEL_LONG + 2 * GLYPH_W + 1);
  localparam int SW = $clog2(PANEL_SHORT + 2 * GLYPH_H + 16);
  localparam int TW = $clog2(PANEL_SHORT);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_DRD   = 3'd2;
  localparam logic [2:0] ST_DWR   = 3'd3;
  localparam logic [2:0] ST_RDAT  = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]          state;
  logic [AW-1:0]       clr_cnt;
  logic                clr_reply;
  logic [GAP_W-1:0]    line_gap;
  logic [LW-1:0]       cur_long;
  logic [SW-1:0]       cur_short;
  logic [LW-1:0]       base_col;
  logic [TW-1:0]       top;
  logic [GLYPH_BITS_W-1:0] glyph_q;
  logic [3:0]          step;
  logic [AW-1:0]       addr_q;
  logic                wr_ok;
  logic                rd_ok;
  logic [BYTE_W-1:0]   data_q;
  logic                drawn_q;

  logic [KIND_W-1:0]       in_kind;
  logic [CODE_W-1:0]       in_code;
  logic [GLYPH_BITS_W-1:0] in_glyph;
  logic [RADDR_W-1:0]      in_addr;
  logic                    accept;

  logic [SW-1:0]       nl_short;
  logic [SW-1:0]       nl_short_fix;
  logic [LW-1:0]       adv_long;
  logic                adv_wrap;
  logic                in_panel;
  logic                drawable;
  logic [LW-1:0]       px;
  logic                px_ok;
  logic [TW-1:0]       kbyte;
  logic [AW-1:0]       addr_calc;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [BYTE_W-1:0]   ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [BYTE_W-1:0]   ram_rdata;
  logic [BYTE_W-1:0]   merged;
  logic                out_free;

  assign in_kind  = s_tuser;
  assign in_code  = s_tdata[7:0];
  assign in_glyph = s_tdata[71:8];
  assign in_addr  = s_tdata[84:72];

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Cursor arithmetic: a newline moves down by glyph height plus the gap and
  // wraps to the top when the next line would not fit.
  always_comb begin
    nl_short     = cur_short + SW'(GLYPH_H) + SW'(line_gap);
    nl_short_fix = ((nl_short + SW'(GLYPH_H)) > SW'(PANEL_SHORT)) ? '0 : nl_short;
    adv_long     = cur_long + LW'(GLYPH_W);
    adv_wrap     = (adv_long + LW'(GLYPH_W)) > LW'(PANEL_LONG);
    in_panel     = (cur_long < LW'(PANEL_LONG)) && (cur_short < SW'(PANEL_SHORT));
    drawable     = (in_code - FIRST_DRAWABLE) < DRAWABLE_COUNT;
  end

  // Byte address of the current glyph column: the column of the page lies at
  // px * ROW_BYTES; the first pixel sits in byte kbyte and the overflow in the
  // byte below it.
  always_comb begin
    px        = base_col + LW'(step[3:1]);
    px_ok     = px < LW'(PANEL_LONG);
    kbyte     = top >> 3;
    addr_calc = AW'(px) * AW'(ROW_BYTES) + AW'(kbyte) - AW'(step[0]);
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_q;
    ram_wdata = merged;
    ram_raddr = addr_calc;
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
        ram_wdata = BYTE_WHITE;
      end
      ST_IDLE: begin
        ram_raddr = AW'(in_addr);
      end
      ST_DWR: begin
        ram_we = wr_ok;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  t2fb_page_ram #(
    .DEPTH (PAGE_BYTES),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  t2fb_mask_unit u_mask (
    .line    (glyph_q[GLYPH_BITS_W-1 -: GLYPH_W]),
    .shift   (top[2:0]),
    .upper   (step[0]),
    .rd_byte (ram_rdata),
    .wr_byte (merged)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      line_gap <= '0;
    end else if (cfg_wen) begin
      line_gap <= cfg_wdata;
    end
  end

  // Sequencer and cursor.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      clr_reply <= 1'b0;
      cur_long  <= '0;
      cur_short <= '0;
      step      <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      // In the finishing state the output register is handled below.
      if (m_tvalid && m_tready && (state != ST_DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          if (clr_cnt == AW'(PAGE_BYTES - 1)) begin
            clr_cnt <= '0;
            state   <= clr_reply ? ST_DONE : ST_IDLE;
          end else begin
            clr_cnt <= clr_cnt + AW'(1);
          end
        end
        ST_IDLE: begin
          if (accept) begin
            data_q   <= '0;
            base_col <= cur_long;
            top      <= TW'(PANEL_SHORT - 1) - TW'(cur_short);
            glyph_q  <= in_glyph;
            step     <= '0;
            rd_ok    <= 32'(in_addr) < 32'(PAGE_BYTES);
            priority case (in_kind)
              KIND_CHAR: begin
                if (in_code == CODE_NEWLINE) begin
                  cur_long  <= '0;
                  cur_short <= nl_short_fix;
                  drawn_q   <= 1'b0;
                  state     <= ST_DONE;
                end else begin
                  if (adv_wrap) begin
                    cur_long  <= '0;
                    cur_short <= nl_short_fix;
                  end else begin
                    cur_long <= adv_long;
                  end
                  if (drawable && in_panel) begin
                    drawn_q <= 1'b1;
                    state   <= ST_DRD;
                  end else begin
                    drawn_q <= 1'b0;
                    state   <= ST_DONE;
                  end
                end
              end
              KIND_CLEAR: begin
                cur_long  <= '0;
                cur_short <= '0;
                clr_reply <= 1'b1;
                drawn_q   <= 1'b0;
                state     <= ST_CLEAR;
              end
              KIND_READ: begin
                drawn_q <= 1'b0;
                state   <= ST_RDAT;
              end
              default: begin
                drawn_q <= 1'b0;
                state   <= ST_DONE;
              end
            endcase
          end
        end
        ST_DRD: begin
          addr_q <= addr_calc;
          // The byte below the first one does not exist on the bottom text row.
          wr_ok  <= px_ok && !(step[0] && (kbyte == '0));
          state  <= ST_DWR;
        end
        ST_DWR: begin
          step <= step + 4'd1;
          if (step[0]) begin
            glyph_q <= glyph_q << GLYPH_W;
          end
          state <= (step == 4'hF) ? ST_DONE : ST_DRD;
        end
        ST_RDAT: begin
          data_q <= rd_ok ? ram_rdata : '0;
          state  <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            m_tvalid  <= 1'b1;
            clr_reply <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      m_tdata <= {7'd0, drawn_q, ROW_W'(cur_short), COL_W'(cur_long), data_q};
    end
  end

  // The buffer is only written by the clearing sweep or a glyph write step.
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE || state == ST_DONE || state == ST_RDAT) |-> !ram_we)
    else $error("page buffer written outside a sweep or glyph step");

  // The cursor always leaves room for a whole glyph.
  a_cursor_fits: assert property (@(posedge clk) disable iff (rst)
    ((cur_long + LW'(GLYPH_W)) <= LW'(PANEL_LONG))
    && ((cur_short + SW'(GLYPH_H)) <= SW'(PANEL_SHORT)))
    else $error("cursor left the panel");

  // The sixteenth glyph byte ends the draw.
  a_draw_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DWR && step == 4'hF) |=> (state == ST_DONE))
    else $error("glyph draw did not finish after sixteen bytes");

  // A result leaving the sequencer reaches the output register.
  a_result_out: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_free) |=> m_tvalid)
    else $error("finished result was not presented");

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the text renderer core: random and directed words, model-based check.
module tb;
  import t2fb_pkg::*;

  localparam int PANEL_LONG  = 296;
  localparam int PANEL_SHORT = 128;
  localparam int PAGE_BYTES  = (PANEL_SHORT / 8) * PANEL_LONG;
  localparam int HALF_PERIOD = 4;
  localparam int RANDOM_PER_PHASE = 408;
  // A clear sweeps the whole page, so the quiet limit sits well above that sweep.
  localparam int QUIET_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 40;
  localparam int MAX_PRINTED = 40;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam logic [CODE_W-1:0] CODE_NUL    = 8'h00;
  localparam logic [CODE_W-1:0] CODE_SOH    = 8'h01;
  localparam logic [CODE_W-1:0] CODE_SPACE  = 8'h20;
  localparam logic [CODE_W-1:0] CODE_TOP    = 8'hFF;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [CODE_W-1:0]       code;
    logic [GLYPH_BITS_W-1:0] glyph;
    logic [RADDR_W-1:0]      addr;
  } text_item_t;

  // Same bit order as the low 25 bits of m_tdata.
  typedef struct packed {
    logic              drawn;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [BYTE_W-1:0] read_data;
  } render_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [KIND_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic cfg_wen = 1'b0;
  logic [GAP_W-1:0] cfg_wdata = '0;

  text_to_framebuffer_renderer_core #(
    .PANEL_LONG (PANEL_LONG),
    .PANEL_SHORT(PANEL_SHORT)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata)
  );

  always #HALF_PERIOD clk = ~clk;

  // Shadow copy of the page buffer, cursor and line gap.
  logic [BYTE_W-1:0] page_model [PAGE_BYTES];
  int unsigned cur_col;
  int unsigned cur_row;
  int unsigned gap_model;

  text_item_t     text_items [$];
  render_result_t expected_renders [$];
  text_item_t     held_item;
  idle_mode_t     idle_mode = IDLE_NONE;
  int unsigned    quiet_cycles = 0;
  int unsigned    mismatches = 0;
  int unsigned    words_in = 0;
  int unsigned    results_checked = 0;
  int unsigned    glyphs_drawn = 0;
  int unsigned    byte_reads = 0;
  int unsigned    page_clears = 0;
  int unsigned    mid_gap;

  function automatic void advance_line();
    cur_row += GLYPH_H + gap_model;
    cur_col = 0;
    if (cur_row + GLYPH_H > PANEL_SHORT) cur_row = 0;
  endfunction

  function automatic render_result_t render_step(text_item_t it);
    render_result_t r;
    logic [CODE_W-1:0] drawable_ofs;
    logic [7:0] glyph_row;
    int unsigned j, i, px, sy, py, idx;
    r = '0;
    case (it.kind)
      KIND_CHAR: begin
        if (it.code == CODE_NEWLINE) begin
          advance_line();
        end else begin
          // The offset wraps in eight bits, so code zero falls inside the drawable set.
          drawable_ofs = it.code - FIRST_DRAWABLE;
          if (cur_col < PANEL_LONG && cur_row < PANEL_SHORT &&
              drawable_ofs < DRAWABLE_COUNT) begin
            r.drawn = 1'b1;
            glyphs_drawn++;
            for (j = 0; j < GLYPH_H; j++) begin
              glyph_row = it.glyph[GLYPH_BITS_W-1-8*j -: 8];
              px = cur_col + j;
              if (px < PANEL_LONG) begin
                for (i = 0; i < GLYPH_W; i++) begin
                  sy = cur_row + i;
                  if (glyph_row[7-i] && sy <= PANEL_SHORT - 1) begin
                    // Mirrored across the short side, MSB of each byte on top.
                    py = PANEL_SHORT - 1 - sy;
                    idx = py / 8 + px * (PANEL_SHORT / 8);
                    if (idx < PAGE_BYTES) page_model[idx][7 - py % 8] = 1'b0;
                  end
                end
              end
            end
          end
          cur_col += GLYPH_W;
          if (cur_col + GLYPH_W > PANEL_LONG) advance_line();
        end
      end
      KIND_CLEAR: begin
        foreach (page_model[k]) page_model[k] = BYTE_WHITE;
        cur_col = 0;
        cur_row = 0;
        page_clears++;
      end
      KIND_READ: begin
        if (it.addr < PAGE_BYTES) r.read_data = page_model[it.addr];
        byte_reads++;
      end
      default: ;
    endcase
    r.col = cur_col[COL_W-1:0];
    r.row = cur_row[ROW_W-1:0];
    return r;
  endfunction

  function automatic text_item_t make_item(logic [KIND_W-1:0] kind, logic [CODE_W-1:0] code,
                                           logic [GLYPH_BITS_W-1:0] glyph,
                                           logic [RADDR_W-1:0] addr);
    text_item_t it;
    it.kind = kind;
    it.code = code;
    it.glyph = glyph;
    it.addr = addr;
    return it;
  endfunction

  // Mostly characters so the page fills with text; clears are rare since each one
  // costs a full sweep of the buffer.
  function automatic text_item_t random_item();
    text_item_t it;
    int unsigned pick;
    it = make_item(KIND_CHAR, CODE_W'($urandom_range(255)), {$urandom, $urandom},
                   RADDR_W'($urandom_range(PAGE_BYTES - 1)));
    pick = $urandom_range(999);
    if (pick < 10) begin
      it.kind = KIND_CLEAR;
    end else if (pick < 30) begin
      it.kind = KIND_UNUSED;
    end else if (pick < 230) begin
      it.kind = KIND_READ;
    end else if (pick < 280) begin
      it.kind = KIND_READ;
      it.addr = RADDR_W'($urandom_range(2**RADDR_W - 1));
    end else if (pick < 360) begin
      it.code = CODE_NEWLINE;
    end else if (pick < 400) begin
      it.code = CODE_W'($urandom_range(CODE_SPACE));
    end
    return it;
  endfunction

  // Gaps on the sending side and stalls on the receiving side, by phase.
  function automatic bit take_gap(bit sender);
    int unsigned pct;
    case (idle_mode)
      IDLE_SENDER:   pct = sender ? 54 : 0;
      IDLE_RECEIVER: pct = sender ? 0 : 54;
      IDLE_BOTH:     pct = 38;
      default:       pct = 0;
    endcase
    return $urandom_range(99) < pct;
  endfunction

  task automatic report_mismatch(string what);
    if (mismatches < MAX_PRINTED) $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // Driver: predicts on acceptance, then offers the next pending word.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_renders.push_back(render_step(held_item));
        words_in++;
      end
      if (!s_tvalid || s_tready) begin
        if (text_items.size() != 0 && !take_gap(1'b1)) begin
          held_item = text_items.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {{(S_TDATA_W - RADDR_W - GLYPH_BITS_W - CODE_W){1'b0}},
                      held_item.addr, held_item.glyph, held_item.code};
          s_tuser <= held_item.kind;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted word against the oldest prediction.
  always @(posedge clk) begin
    render_result_t got, want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[$bits(render_result_t)-1:0];
        if (expected_renders.size() == 0) begin
          report_mismatch($sformatf("unexpected result word %h", m_tdata));
        end else begin
          want = expected_renders.pop_front();
          results_checked++;
          if (got.read_data !== want.read_data)
            report_mismatch($sformatf("read_data %h, want %h", got.read_data, want.read_data));
          if (got.col !== want.col)
            report_mismatch($sformatf("cursor_col %0d, want %0d", got.col, want.col));
          if (got.row !== want.row)
            report_mismatch($sformatf("cursor_row %0d, want %0d", got.row, want.row));
          if (got.drawn !== want.drawn)
            report_mismatch($sformatf("drawn %b, want %b", got.drawn, want.drawn));
        end
      end
      m_tready <= !take_gap(1'b0);
    end
  end

  // Watchdog: a hang shows as a long run of cycles with no word moving on either side.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles, %0d results outstanding.",
               QUIET_LIMIT, expected_renders.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic wait_until_drained();
    while (text_items.size() != 0 || s_tvalid || expected_renders.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int unsigned ph;
    logic [GAP_W-1:0] new_gap;
    foreach (page_model[k]) page_model[k] = BYTE_WHITE;
    cur_col = 0;
    cur_row = 0;
    gap_model = 0;
    mid_gap = $urandom_range(14, 1);
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (ph = 0; ph < 4; ph++) begin
      if (ph != 0) begin
        wait_until_drained();
        case (ph)
          1: new_gap = '1;
          2: new_gap = '0;
          default: new_gap = mid_gap[GAP_W-1:0];
        endcase
        @(posedge clk);
        cfg_wen <= 1'b1;
        cfg_wdata <= new_gap;
        gap_model = 32'(new_gap);
        @(posedge clk);
        cfg_wen <= 1'b0;
      end
      idle_mode = idle_mode_t'(ph);
      if (ph == 0) begin
        // Fresh page: corners and out-of-range reads, then the drawable boundaries.
        text_items.push_back(make_item(KIND_READ, '0, '0, '0));
        text_items.push_back(make_item(KIND_READ, '1, '1, RADDR_W'(PAGE_BYTES - 1)));
        text_items.push_back(make_item(KIND_READ, '0, '0, RADDR_W'(PAGE_BYTES)));
        text_items.push_back(make_item(KIND_READ, '0, '0, '1));
        text_items.push_back(make_item(KIND_CHAR, FIRST_DRAWABLE, '1, '0));
        text_items.push_back(make_item(KIND_READ, '0, '0, RADDR_W'(15)));
        text_items.push_back(make_item(KIND_CHAR, CODE_TOP, 64'h8040201008040201, '0));
        text_items.push_back(make_item(KIND_READ, '0, '0, RADDR_W'(143)));
        text_items.push_back(make_item(KIND_CHAR, CODE_NUL, {$urandom, $urandom}, '0));
        text_items.push_back(make_item(KIND_CHAR, CODE_SOH, '1, '0));
        text_items.push_back(make_item(KIND_CHAR, CODE_SPACE, '1, '0));
        text_items.push_back(make_item(KIND_CHAR, 8'h7F, '0, '0));
        text_items.push_back(make_item(KIND_CHAR, CODE_NEWLINE, '1, '1));
        text_items.push_back(make_item(KIND_CHAR, 8'h41, {$urandom, $urandom}, '0));
        text_items.push_back(make_item(KIND_UNUSED, 8'h41, '1, RADDR_W'(15)));
        text_items.push_back(make_item(KIND_READ, '0, '0, RADDR_W'(31)));
        text_items.push_back(make_item(KIND_READ, '0, '0, RADDR_W'(271)));
        text_items.push_back(make_item(KIND_CLEAR, 8'h41, '1, RADDR_W'(15)));
        text_items.push_back(make_item(KIND_READ, '0, '0, RADDR_W'(15)));
        text_items.push_back(make_item(KIND_CHAR, 8'h42, 64'hFF818181818181FF, '0));
        text_items.push_back(make_item(KIND_READ, '0, '0, RADDR_W'(15)));
      end
      repeat (RANDOM_PER_PHASE) text_items.push_back(random_item());
    end

    wait_until_drained();
    $display("Run: %0d words in, %0d results checked; %0d glyphs drawn, %0d byte reads,",
             words_in, results_checked, glyphs_drawn, byte_reads);
    $display("     %0d page clears; line gaps 0, 15, 0 and %0d; %0d mismatches.",
             page_clears, mid_gap, mismatches);
    if (mismatches == 0 && expected_renders.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/t2fb_pkg.sv
design/t2fb_page_ram.sv
design/t2fb_mask_unit.sv
design/text_to_framebuffer_renderer_core.sv
tb/sv/tb.sv
